[design/hds_pkg.sv]
// Shared types, codes and constants of the heat diffusion stencil.
`timescale 1ns / 1ps
package hds_pkg;

    // Default grid limits.
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Scaling by 0.2 in Q0.16.
    localparam logic signed [15:0] FIFTH_Q16 = 16'sd13107;

    // Operation codes.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_STEPS  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [6:0]  RESET_WIDTH  = 7'd64;
    localparam logic [6:0]  RESET_HEIGHT = 7'd64;
    localparam logic [15:0] RESET_STEPS  = 16'd32;

    // Grid geometry as seen by front and back.
    typedef struct packed {
        logic [6:0]  width;
        logic [6:0]  height;
        logic [15:0] steps;
    } t_geom;

    // One classified word in the queue.
    typedef struct packed {
        logic [1:0]         op;
        logic [11:0]        idx;
        logic signed [31:0] temp;
        logic [16:0]        cond;
        logic               bad;
    } t_item;

    // Queue status toward front and back.
    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

    // Sequencer states of the back end.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_RDREQ,
        ST_RDDATA,
        ST_SWEEP
    } t_state;

endpackage

[design/hds_in_if.sv]
// Input channel of the heat diffusion stencil.
`timescale 1ns / 1ps
interface hds_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [11:0]        cell_index;
    logic signed [31:0] cell_temperature;
    logic [16:0]        cell_conductance;

    modport source (output valid, operation, cell_index, cell_temperature,
                    cell_conductance, input ready);
    modport sink (input valid, operation, cell_index, cell_temperature,
                  cell_conductance, output ready);
endinterface

[design/hds_out_if.sv]
// Result channel of the heat diffusion stencil.
`timescale 1ns / 1ps
interface hds_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_temperature;
    logic               status;

    modport source (output valid, read_temperature, status, input ready);
    modport sink (input valid, read_temperature, status, output ready);
endinterface

[design/hds_queue.sv]
// Two-entry queue of classified words between front and back.
`timescale 1ns / 1ps
module hds_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hds_pkg::t_item i_push_item,
    input  logic           i_pop,
    output hds_pkg::t_item o_head,
    output hds_pkg::t_qstat o_stat
);
    localparam int PW = $clog2(hds_pkg::QUEUE_DEPTH);

    hds_pkg::t_item r_mem [hds_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_push_item;
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == (PW+1)'(hds_pkg::QUEUE_DEPTH));
endmodule

[design/hds_front.sv]
// Front end: accepts input words and checks the cell index against the grid.
`timescale 1ns / 1ps
module hds_front (
    hds_in_if.sink          i_in,
    input  hds_pkg::t_geom  i_geom,
    input  hds_pkg::t_qstat i_qstat,
    output logic            o_push,
    output hds_pkg::t_item  o_item
);
    logic [13:0] cells;

    // Number of cells in use.
    assign cells = 14'(i_geom.width * i_geom.height);

    // Accept whenever the queue has room.
    assign i_in.ready = !i_qstat.full;
    assign o_push     = i_in.valid && !i_qstat.full;

    // Classified word.
    always_comb begin
        o_item.op   = i_in.operation;
        o_item.idx  = i_in.cell_index;
        o_item.temp = i_in.cell_temperature;
        o_item.cond = i_in.cell_conductance;
        o_item.bad  = ({2'b00, i_in.cell_index} >= cells);
    end
endmodule

[design/hds_back.sv]
// Back end: grid memories, substep sweep sequencer and result register.
`timescale 1ns / 1ps
module hds_back #(
    parameter int MAX_WIDTH  = hds_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = hds_pkg::MAX_HEIGHT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hds_pkg::t_geom  i_geom,
    input  hds_pkg::t_item  i_head,
    input  hds_pkg::t_qstat i_qstat,
    output logic            o_pop,
    hds_out_if.source       o_out
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // Memories: two temperature banks and the conductance grid.
    logic [31:0] r_mem0 [DEPTH];
    logic [31:0] r_mem1 [DEPTH];
    logic [16:0] r_memc [DEPTH];
    logic [31:0] r_rd0, r_rd1;
    logic [16:0] r_rdc;

    hds_pkg::t_state r_state, n_state;
    logic        r_cur;
    logic        r_out_v;
    logic signed [31:0] r_out_t;
    logic        r_out_s;

    logic [6:0]  r_x, r_y;
    logic [AW-1:0] r_c, r_addr;
    logic [15:0] r_step;
    logic [3:0]  r_ph;
    logic [31:0] r_t;
    logic signed [32:0] r_diff;
    logic [16:0] r_cnd;
    logic signed [50:0] r_prod;
    logic signed [52:0] r_sum;
    logic signed [52:0] r_scl;
    logic [6:0]  r_rem;
    logic [11:0] r_quo;
    logic [3:0]  r_dcnt;

    logic [6:0]  w_in, h_in;
    logic        last_x, last_y, cell_end, step_end, run_end, div_end;
    logic        out_free, out_take;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0] wr_data, rd_t;
    logic        we0, we1, wec;
    logic        nb_border;
    logic signed [32:0] diff;
    logic [7:0]  sh;
    logic        qbit;
    logic [6:0]  cx, cy;

    assign w_in = 7'(i_geom.width - 7'd2);
    assign h_in = 7'(i_geom.height - 7'd2);

    assign last_x   = (r_x == w_in);
    assign last_y   = (r_y == h_in);
    assign cell_end = (r_ph == 4'd9);
    assign step_end = cell_end && last_x && last_y;
    assign run_end  = step_end && (r_step == 16'(i_geom.steps - 16'd1));
    assign div_end  = (r_dcnt == 4'd11);

    assign out_take = r_out_v && o_out.ready;
    assign out_free = !r_out_v || o_out.ready;

    assign rd_t = r_cur ? r_rd1 : r_rd0;

    // Restoring divide step, one quotient bit a cycle.
    assign sh   = {r_rem, r_quo[11]};
    assign qbit = (sh >= {1'b0, i_geom.width});

    // Clamp column and row of a read to the interior.
    always_comb begin
        if (r_rem == 7'd0)      cx = 7'd1;
        else if (r_rem > w_in)  cx = w_in;
        else                    cx = r_rem;
        if (r_quo == 12'd0)               cy = 7'd1;
        else if (r_quo > {5'd0, h_in})    cy = h_in;
        else                              cy = 7'(r_quo);
    end

    // Border neighbors replicate the center, so they add nothing.
    always_comb begin
        case (r_ph)
            4'd2:    nb_border = (r_x == 7'd1);
            4'd3:    nb_border = last_x;
            4'd4:    nb_border = (r_y == 7'd1);
            default: nb_border = last_y;
        endcase
    end
    assign diff = nb_border ? 33'sd0
                : $signed({rd_t[31], rd_t}) - $signed({r_t[31], r_t});

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hds_pkg::ST_IDLE: begin
                if (i_qstat.valid && out_free) begin
                    if (i_head.op == hds_pkg::OP_RUN && i_geom.steps != 16'd0)
                        n_state = hds_pkg::ST_SWEEP;
                    else if (i_head.op == hds_pkg::OP_READ && !i_head.bad)
                        n_state = hds_pkg::ST_DIV;
                end
            end
            hds_pkg::ST_DIV:    if (div_end) n_state = hds_pkg::ST_ADDR;
            hds_pkg::ST_ADDR:   n_state = hds_pkg::ST_RDREQ;
            hds_pkg::ST_RDREQ:  n_state = hds_pkg::ST_RDDATA;
            hds_pkg::ST_RDDATA: n_state = hds_pkg::ST_IDLE;
            hds_pkg::ST_SWEEP:  if (run_end) n_state = hds_pkg::ST_IDLE;
            default:            n_state = hds_pkg::ST_IDLE;
        endcase
    end

    // Memory controls and queue pop.
    always_comb begin
        o_pop   = 1'b0;
        rd_addr = r_c;
        wr_addr = r_c;
        wr_data = 32'(r_t + r_scl[47:16]);
        we0     = 1'b0;
        we1     = 1'b0;
        wec     = 1'b0;
        unique case (r_state)
            hds_pkg::ST_IDLE: begin
                o_pop   = i_qstat.valid && out_free;
                wr_addr = AW'(i_head.idx);
                wr_data = i_head.temp;
                if (o_pop && i_head.op == hds_pkg::OP_LOAD && !i_head.bad) begin
                    we0 = !r_cur;
                    we1 = r_cur;
                    wec = 1'b1;
                end
            end
            hds_pkg::ST_RDREQ: rd_addr = r_addr;
            hds_pkg::ST_SWEEP: begin
                case (r_ph)
                    4'd1:    rd_addr = r_c - AW'(1);
                    4'd2:    rd_addr = r_c + AW'(1);
                    4'd3:    rd_addr = r_c - AW'(i_geom.width);
                    4'd4:    rd_addr = r_c + AW'(i_geom.width);
                    default: rd_addr = r_c;
                endcase
                we0 = cell_end && r_cur;
                we1 = cell_end && !r_cur;
            end
            default: ;
        endcase
    end

    // Temperature banks and conductance grid.
    always_ff @(posedge i_clk) begin
        if (we0) r_mem0[wr_addr] <= wr_data;
        if (we1) r_mem1[wr_addr] <= wr_data;
        if (wec) r_memc[wr_addr] <= i_head.cond;
        r_rd0 <= r_mem0[rd_addr];
        r_rd1 <= r_mem1[rd_addr];
        r_rdc <= r_memc[rd_addr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hds_pkg::ST_IDLE;
            r_cur   <= 1'b0;
            r_out_v <= 1'b0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == hds_pkg::ST_SWEEP) begin
                r_ph <= cell_end ? 4'd0 : 4'(r_ph + 4'd1);
                if (step_end) r_cur <= !r_cur;
            end else begin
                r_ph <= '0;
            end
            if (out_take) r_out_v <= 1'b0;
            if ((r_state == hds_pkg::ST_IDLE && o_pop &&
                 !(i_head.op == hds_pkg::OP_RUN && i_geom.steps != 16'd0) &&
                 !(i_head.op == hds_pkg::OP_READ && !i_head.bad)) ||
                r_state == hds_pkg::ST_RDDATA ||
                (r_state == hds_pkg::ST_SWEEP && run_end))
                r_out_v <= 1'b1;
        end
    end

    // Datapath and counters.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hds_pkg::ST_IDLE: begin
                r_rem   <= '0;
                r_quo   <= i_head.idx;
                r_dcnt  <= '0;
                r_step  <= '0;
                r_x     <= 7'd1;
                r_y     <= 7'd1;
                r_c     <= AW'(i_geom.width + 7'd1);
                // A waiting result word keeps its payload until it is taken.
                if (o_pop) begin
                    r_out_t <= '0;
                    r_out_s <= ((i_head.op == hds_pkg::OP_LOAD) ||
                                (i_head.op == hds_pkg::OP_READ)) && i_head.bad;
                end
            end
            hds_pkg::ST_DIV: begin
                r_rem  <= qbit ? 7'(sh - {1'b0, i_geom.width}) : 7'(sh);
                r_quo  <= {r_quo[10:0], qbit};
                r_dcnt <= 4'(r_dcnt + 4'd1);
            end
            hds_pkg::ST_ADDR:   r_addr <= AW'(cy * i_geom.width + {7'd0, cx});
            hds_pkg::ST_RDREQ:  ;
            hds_pkg::ST_RDDATA: begin
                r_out_t <= rd_t;
                r_out_s <= 1'b0;
            end
            hds_pkg::ST_SWEEP: begin
                if (r_ph == 4'd0) r_sum <= '0;
                if (r_ph == 4'd1) r_t <= rd_t;
                if (r_ph >= 4'd2 && r_ph <= 4'd5) begin
                    r_diff <= diff;
                    r_cnd  <= r_rdc;
                end
                if (r_ph >= 4'd3 && r_ph <= 4'd6)
                    r_prod <= r_diff * $signed({1'b0, r_cnd});
                if (r_ph >= 4'd4 && r_ph <= 4'd7)
                    r_sum <= r_sum + 53'(r_prod);
                if (r_ph == 4'd8)
                    r_scl <= $signed(r_sum[52:16]) * hds_pkg::FIFTH_Q16;
                if (cell_end) begin
                    if (!last_x) begin
                        r_x <= 7'(r_x + 7'd1);
                        r_c <= r_c + AW'(1);
                    end else if (!last_y) begin
                        r_x <= 7'd1;
                        r_y <= 7'(r_y + 7'd1);
                        r_c <= r_c + AW'(3);
                    end else begin
                        r_x    <= 7'd1;
                        r_y    <= 7'd1;
                        r_c    <= AW'(i_geom.width + 7'd1);
                        r_step <= 16'(r_step + 16'd1);
                    end
                end
                r_out_t <= '0;
                r_out_s <= 1'b0;
            end
            default: ;
        endcase
    end

    assign o_out.valid            = r_out_v;
    assign o_out.read_temperature = r_out_t;
    assign o_out.status           = r_out_s;
endmodule

[design/heat_diffusion_stencil.sv]
// Top level of the five-point heat diffusion stencil.
// Load and unused-code words are handled in the back end's idle state; a read
// divides the index by the width, forms the address and reads the memory.
// A run sweeps each interior cell once per substep: the sweep sequencer reads
// the center and its four neighbors in turn on the single memory read port.
// Reset restores control and configuration; the grid memories are not cleared.
`timescale 1ns / 1ps
module heat_diffusion_stencil #(
    parameter int MAX_WIDTH  = hds_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = hds_pkg::MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hds_in_if.sink      i_in,
    hds_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    localparam int WHI = (MAX_WIDTH  < 127) ? MAX_WIDTH  : 127;
    localparam int HHI = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;

    logic [6:0]  r_w, r_h;
    logic [15:0] r_steps;
    logic [6:0]  cfg_v, w_clamp, h_clamp;

    hds_pkg::t_geom  geom;
    hds_pkg::t_item  push_item, head;
    hds_pkg::t_qstat qstat;
    logic            push, pop;

    // Saturate geometry writes to the supported range.
    assign cfg_v   = i_cfg_data[6:0];
    assign w_clamp = (cfg_v < 7'd3) ? 7'd3 : ((cfg_v > 7'(WHI)) ? 7'(WHI) : cfg_v);
    assign h_clamp = (cfg_v < 7'd3) ? 7'd3 : ((cfg_v > 7'(HHI)) ? 7'(HHI) : cfg_v);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= (hds_pkg::RESET_WIDTH  > 7'(WHI)) ? 7'(WHI) : hds_pkg::RESET_WIDTH;
            r_h     <= (hds_pkg::RESET_HEIGHT > 7'(HHI)) ? 7'(HHI) : hds_pkg::RESET_HEIGHT;
            r_steps <= hds_pkg::RESET_STEPS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hds_pkg::CFG_WIDTH:  r_w     <= w_clamp;
                hds_pkg::CFG_HEIGHT: r_h     <= h_clamp;
                hds_pkg::CFG_STEPS:  r_steps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign geom.width  = r_w;
    assign geom.height = r_h;
    assign geom.steps  = r_steps;

    hds_front u_front (
        .i_in    (i_in),
        .i_geom  (geom),
        .i_qstat (qstat),
        .o_push  (push),
        .o_item  (push_item)
    );

    hds_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (qstat)
    );

    hds_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> qstat.valid)
        else $error("queue popped while empty");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("queue pushed while full");

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == hds_pkg::CFG_WIDTH) |=>
        (r_w >= 7'd3 && r_w <= 7'(WHI)))
        else $error("grid width left its range");
`endif
endmodule

[bench/hds_checker.sv]
// Scoreboard of the heat diffusion stencil: watches both channels, predicts each result word.
`timescale 1ns / 1ps
module hds_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hds_in_if           i_in,
    hds_out_if          i_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_outstanding
);

    localparam int CELLS = hds_pkg::MAX_WIDTH * hds_pkg::MAX_HEIGHT;

    // Result word as the block should return it.
    typedef struct packed {
        logic [31:0] temp;
        logic        status;
    } t_cell_reply;

    t_cell_reply expected_replies[$];

    // Shadow copy of the grids and the geometry.
    logic [31:0] temp_now [CELLS];
    logic [31:0] temp_new [CELLS];
    logic [16:0] cond_map [CELLS];
    int          cols;
    int          rows;
    int          sweeps;

    assign o_outstanding = expected_replies.size();

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // A border cell mirrors its nearest interior cell.
    function automatic logic [31:0] edge_source(int x, int y);
        int cx;
        int cy;
        cx = clamp_int(x, 1, cols - 2);
        cy = clamp_int(y, 1, rows - 2);
        return temp_now[cy * cols + cx];
    endfunction

    // One diffusion substep over the whole grid.
    task automatic diffuse_once();
        int     c;
        int     nb [4];
        longint t;
        longint sum;
        longint delta;
        for (int y = 0; y < rows; y++) begin
            for (int x = 0; x < cols; x++) begin
                if (x == 0 || y == 0 || x == cols - 1 || y == rows - 1) begin
                    temp_now[y * cols + x] = edge_source(x, y);
                end
            end
        end
        for (int y = 1; y + 1 < rows; y++) begin
            for (int x = 1; x + 1 < cols; x++) begin
                c = y * cols + x;
                nb[0] = c - 1;
                nb[1] = c + 1;
                nb[2] = c - cols;
                nb[3] = c + cols;
                t = longint'($signed(temp_now[c]));
                sum = 0;
                for (int k = 0; k < 4; k++) begin
                    sum += (longint'($signed(temp_now[nb[k]])) - t) *
                           longint'({47'd0, cond_map[nb[k]]});
                end
                delta = ((sum >>> 16) * 13107) >>> 16;
                temp_new[c] = 32'(t + delta);
            end
        end
        temp_now = temp_new;
    endtask

    // Apply one accepted word to the shadow state and queue its reply.
    task automatic predict_word(logic [1:0] op, logic [11:0] idx, logic [31:0] temp,
                                logic [16:0] cond);
        t_cell_reply r;
        int          pos;
        r = '0;
        pos = int'(idx);
        case (op)
            hds_pkg::OP_LOAD: begin
                if (pos < cols * rows) begin
                    temp_now[pos] = temp;
                    cond_map[pos] = cond;
                end else begin
                    r.status = 1'b1;
                end
            end
            hds_pkg::OP_RUN: begin
                for (int s = 0; s < sweeps; s++) diffuse_once();
            end
            hds_pkg::OP_READ: begin
                if (pos < cols * rows) begin
                    r.temp = edge_source(pos % cols, pos / cols);
                end else begin
                    r.status = 1'b1;
                end
            end
            default: ;
        endcase
        expected_replies.push_back(r);
    endtask

    // Track configuration, compare results, then predict new words.
    always @(posedge i_clk) begin
        t_cell_reply want;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            cols = clamp_int(int'(hds_pkg::RESET_WIDTH), 3, hds_pkg::MAX_WIDTH);
            rows = clamp_int(int'(hds_pkg::RESET_HEIGHT), 3, hds_pkg::MAX_HEIGHT);
            sweeps = int'(hds_pkg::RESET_STEPS);
            expected_replies.delete();
            o_fail_count <= 0;
            for (int i = 0; i < CELLS; i++) begin
                temp_now[i] = '0;
                temp_new[i] = '0;
                cond_map[i] = '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hds_pkg::CFG_WIDTH:
                        cols = clamp_int(int'(i_cfg_data[6:0]), 3, hds_pkg::MAX_WIDTH);
                    hds_pkg::CFG_HEIGHT:
                        rows = clamp_int(int'(i_cfg_data[6:0]), 3, hds_pkg::MAX_HEIGHT);
                    hds_pkg::CFG_STEPS:
                        sweeps = int'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_replies.size() == 0) begin
                    $error("result word with nothing expected");
                    errs++;
                end else begin
                    want = expected_replies.pop_front();
                    if (i_out.read_temperature !== want.temp) begin
                        $error("read_temperature: expected %h, got %h", want.temp,
                               i_out.read_temperature);
                        errs++;
                    end
                    if (i_out.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out.status);
                        errs++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_word(i_in.operation, i_in.cell_index, i_in.cell_temperature,
                             i_in.cell_conductance);
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

[bench/heat_diffusion_stencil_tb.sv]
// Testbench top of the heat diffusion stencil: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module heat_diffusion_stencil_tb;

    localparam logic [1:0] OP_SPARE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;
    int          fail_count;
    int          outstanding;
    int          cur_w;
    int          cur_h;
    int          sent_words;

    hds_in_if  in_ch ();
    hds_out_if out_ch ();

    heat_diffusion_stencil uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hds_checker scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Clock, 4 ns period.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Gap lengths: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver flow control with one long hold-off early in the run.
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(logic [1:0] op, logic [11:0] idx, logic [31:0] temp,
                             logic [16:0] cond);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.operation        <= op;
        in_ch.cell_index       <= idx;
        in_ch.cell_temperature <= temp;
        in_ch.cell_conductance <= cond;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_words++;
    endtask

    // Wait until every expected result has come, then write one register.
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_geometry(int w_val, int h_val, int steps_val);
        write_reg(hds_pkg::CFG_WIDTH, 16'(w_val));
        write_reg(hds_pkg::CFG_HEIGHT, 16'(h_val));
        write_reg(hds_pkg::CFG_STEPS, 16'(steps_val));
        cur_w = (w_val < 3) ? 3 : ((w_val > hds_pkg::MAX_WIDTH) ? hds_pkg::MAX_WIDTH : w_val);
        cur_h = (h_val < 3) ? 3 :
                ((h_val > hds_pkg::MAX_HEIGHT) ? hds_pkg::MAX_HEIGHT : h_val);
    endtask

    function automatic logic [31:0] pick_temp();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    endfunction

    function automatic logic [16:0] pick_cond();
        if ($urandom_range(0, 7) == 0) return 17'($urandom_range(65537, 131071));
        return 17'($urandom_range(0, 65536));
    endfunction

    // Fill every cell in use so that no run or read touches an unwritten entry.
    task automatic fill_grid();
        for (int i = 0; i < cur_w * cur_h; i++) begin
            send_word(hds_pkg::OP_LOAD, 12'(i), pick_temp(), pick_cond());
        end
    endtask

    // A mix of loads, reads, runs and spare codes with random content.
    task automatic random_mix(int count);
        int          r;
        logic [11:0] idx;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) idx = 12'($urandom);
            else idx = 12'($urandom_range(0, cur_w * cur_h - 1));
            if (r < 45) send_word(hds_pkg::OP_LOAD, idx, pick_temp(), pick_cond());
            else if (r < 85) send_word(hds_pkg::OP_READ, idx, $urandom, 17'($urandom));
            else if (r < 95) send_word(hds_pkg::OP_RUN, 12'($urandom), $urandom,
                                       17'($urandom));
            else send_word(OP_SPARE, 12'($urandom), $urandom, 17'($urandom));
        end
    endtask

    // Stimulus.
    initial begin
        int w_val;
        int h_val;
        in_ch.valid            <= 1'b0;
        in_ch.operation        <= hds_pkg::OP_LOAD;
        in_ch.cell_index       <= '0;
        in_ch.cell_temperature <= '0;
        in_ch.cell_conductance <= '0;
        cfg_we                 <= 1'b0;
        cfg_idx                <= hds_pkg::CFG_WIDTH;
        cfg_data               <= '0;
        sent_words = 0;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: smallest grid via saturation, extreme values, all codes.
        set_geometry(2, 1, 1);
        send_word(hds_pkg::OP_LOAD, 12'd0, 32'h8000_0000, 17'd0);
        send_word(hds_pkg::OP_LOAD, 12'd1, 32'h7fff_ffff, 17'd131071);
        send_word(hds_pkg::OP_LOAD, 12'd2, 32'h0000_0000, 17'd65536);
        send_word(hds_pkg::OP_LOAD, 12'd3, 32'hffff_ffff, 17'd65536);
        send_word(hds_pkg::OP_LOAD, 12'd4, 32'h7fff_ffff, 17'd1);
        send_word(hds_pkg::OP_LOAD, 12'd5, 32'h8000_0000, 17'd131071);
        send_word(hds_pkg::OP_LOAD, 12'd6, 32'h0001_0000, 17'd32768);
        send_word(hds_pkg::OP_LOAD, 12'd7, 32'hfffe_0000, 17'd0);
        send_word(hds_pkg::OP_LOAD, 12'd8, 32'h1234_5678, 17'd65535);
        send_word(hds_pkg::OP_LOAD, 12'd4095, 32'h5555_aaaa, 17'h1ffff);
        send_word(hds_pkg::OP_READ, 12'd4095, 32'h0, 17'd0);
        send_word(hds_pkg::OP_READ, 12'd0, 32'h0, 17'd0);
        send_word(hds_pkg::OP_READ, 12'd4, 32'h0, 17'd0);
        send_word(OP_SPARE, 12'hfff, 32'hffff_ffff, 17'h1ffff);
        send_word(hds_pkg::OP_RUN, 12'd0, 32'h0, 17'd0);
        send_word(hds_pkg::OP_READ, 12'd4, 32'h0, 17'd0);
        send_word(hds_pkg::OP_READ, 12'd8, 32'h0, 17'd0);

        // Zero substeps leave the grid as it is.
        write_reg(hds_pkg::CFG_STEPS, 16'd0);
        send_word(hds_pkg::OP_RUN, 12'd0, 32'h0, 17'd0);
        send_word(hds_pkg::OP_READ, 12'd4, 32'h0, 17'd0);

        // Widest and tallest grids, with width saturated from above.
        set_geometry(127, 3, 2);
        fill_grid();
        random_mix(30);
        set_geometry(3, 64, 2);
        fill_grid();
        random_mix(30);

        // Longest run on the smallest grid.
        set_geometry(3, 3, 65535);
        fill_grid();
        send_word(hds_pkg::OP_RUN, 12'd0, 32'h0, 17'd0);
        random_mix(10);

        // Random small geometries.
        while (sent_words < 500) begin
            w_val = $urandom_range(3, 8);
            h_val = $urandom_range(3, 8);
            set_geometry(w_val, h_val, $urandom_range(1, 4));
            fill_grid();
            random_mix(40);
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("heat_diffusion_stencil test passed");
        end else begin
            $display("heat_diffusion_stencil test failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #200_000_000;
        $display("heat_diffusion_stencil test failed");
        $finish;
    end

endmodule

[heat_diffusion_stencil.f]
design/hds_pkg.sv
design/hds_in_if.sv
design/hds_out_if.sv
design/hds_queue.sv
design/hds_front.sv
design/hds_back.sv
design/heat_diffusion_stencil.sv
bench/hds_checker.sv
bench/heat_diffusion_stencil_tb.sv
